// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Types, codes and tone constants shared by the tone sequencer.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int MAX_WIDTH_DEF    = 640;
  localparam int MAX_SEGMENTS_DEF = 8;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  pixel_index;
    logic [23:0] pixel_rgb;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic [18:0] tone_duration_us;
    logic        last;
  } tone_t;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_HEADER = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [2:0] CFG_VIS_CODE   = 3'd0;
  localparam logic [2:0] CFG_LINE_WIDTH = 3'd1;
  localparam logic [2:0] CFG_PIXEL_DUR  = 3'd2;
  localparam logic [2:0] CFG_SEG_COUNT  = 3'd3;
  localparam logic [2:0] CFG_PAIR_0     = 3'd4;
  localparam logic [2:0] CFG_PAIR_1     = 3'd5;
  localparam logic [2:0] CFG_PAIR_2     = 3'd6;
  localparam logic [2:0] CFG_PAIR_3     = 3'd7;

  localparam logic [1:0] SEG_GENERIC = 2'd0;
  localparam logic [1:0] SEG_RED     = 2'd1;
  localparam logic [1:0] SEG_GREEN   = 2'd2;
  localparam logic [1:0] SEG_BLUE    = 2'd3;

  localparam logic [6:0] VIS_SCOTTIE_1  = 7'd60;
  localparam logic [6:0] VIS_SCOTTIE_2  = 7'd56;
  localparam logic [6:0] VIS_SCOTTIE_DX = 7'd76;

  localparam logic [6:0]  VIS_CODE_RST   = 7'd60;
  localparam logic [9:0]  LINE_WIDTH_RST = 10'd320;
  localparam logic [13:0] PIXEL_DUR_RST  = 14'd432;
  localparam logic [3:0]  SEG_COUNT_RST  = 4'd7;

  localparam logic [15:0] F_LEADER     = 16'd30400;
  localparam logic [15:0] F_BREAK      = 16'd19200;
  localparam logic [15:0] F_VIS1       = 16'd17600;
  localparam logic [15:0] F_VIS0       = 16'd20800;
  localparam logic [15:0] F_BRIGHT_MIN = 16'd24000;
  localparam logic [18:0] LEADER_US    = 19'd300000;
  localparam logic [18:0] BREAK_US     = 19'd10000;
  localparam logic [18:0] BIT_US       = 19'd30000;
  localparam logic [18:0] SYNC_US      = 19'd9000;

  localparam logic [3:0] HDR_LEADER_A = 4'd0;
  localparam logic [3:0] HDR_BREAK    = 4'd1;
  localparam logic [3:0] HDR_LEADER_B = 4'd2;
  localparam logic [3:0] HDR_START    = 4'd3;
  localparam logic [3:0] HDR_BIT_0    = 4'd4;
  localparam logic [3:0] HDR_BIT_6    = 4'd10;
  localparam logic [3:0] HDR_PARITY   = 4'd11;
  localparam logic [3:0] HDR_STOP     = 4'd12;

  // 24000 + round(c * 12800 / 255), halves up
  // with y = 50c: y + floor((y + 127) / 255), the quotient by reciprocal 257/2^16
  function automatic logic [15:0] bright_freq(input logic [7:0] c);
    logic [13:0] y;
    logic [13:0] z;
    logic [23:0] p;
    y = {6'd0, c} * 14'd50;
    z = y + 14'd127;
    p = ({10'd0, z} + 24'd1) * 24'd257;
    return F_BRIGHT_MIN + {2'd0, y} + {8'd0, p[23:16]};
  endfunction

endpackage

// ===== rtl/sstv_tone_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sstv_tone_sequencer_unit
// Slow-scan TV transmit sequencer: VIS header and scan line tone commands.
// ----------------------------------------------------------------------------
// One command is taken per clock while no stall holds it. A tone passes the
// first stage and the output register: the segment search and line position
// update happen as the command is taken, together with a registered read of
// the line store, and the colour to frequency step fills the output register.
// A header command emits 13 tones, one per cycle while the receiver takes
// them, and commands wait meanwhile; pixel loads and line ticks that emit
// nothing give no tone. Configuration writes are always ready.
module sstv_tone_sequencer_unit #(
  parameter int MAX_WIDTH    = sts_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SEGMENTS = sts_pkg::MAX_SEGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sts_pkg::cmd_t cmd,
  output logic          tone_valid,
  input  logic          tone_stall,
  output sts_pkg::tone_t tone,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [59:0]   cfg_data
);

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int CW = PW + 1;
  localparam int SW = $clog2(MAX_SEGMENTS);

  typedef enum logic [1:0] {K_DIRECT, K_PIXEL, K_HEADER} kind_t;

  logic [6:0]  vis_code;
  logic [9:0]  line_width;
  logic [13:0] pixel_duration_us;
  logic [3:0]  segment_count;
  logic [59:0] segment_pair [4];

  logic [SW-1:0] seg_pos;
  logic [PW-1:0] pix_pos;
  logic          first_line_pending;

  logic [23:0] line_store [MAX_WIDTH];
  logic [23:0] rd_data;

  logic        s1_valid;
  kind_t       s1_kind;
  logic [15:0] s1_freq;
  logic [18:0] s1_dur;
  logic        s1_last;
  logic [1:0]  s1_chan;
  logic [3:0]  s1_count;

  logic accept, out_free, s1_done;

  logic [3:0]    n_eff;
  logic [CW-1:0] w_eff;
  logic [29:0]   seg_v [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] e0;

  logic          found, any_e, rest, e_pos;
  logic [SW-1:0] s_sel;
  logic [29:0]   sel_v;
  logic [PW-1:0] pix;
  logic [CW-1:0] pix_inc;
  logic          sel_generic, scan_end, line_last, is_scottie, do_sync;
  logic [15:0]   gen_freq;
  logic [PW-1:0] rd_addr;

  logic [7:0]      colour;
  logic            parity;
  sts_pkg::tone_t  tone_next;

  assign cfg_ready = 1'b1;

  // segment decode
  always_comb begin
    n_eff = (32'(segment_count) > MAX_SEGMENTS) ? 4'(MAX_SEGMENTS) : segment_count;
    w_eff = (32'(line_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(line_width);
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_v[i] = (i % 2 == 1) ? segment_pair[i / 2][59:30] : segment_pair[i / 2][29:0];
      e0[i]    = (seg_v[i][1:0] == sts_pkg::SEG_GENERIC) ? (seg_v[i][15:2] != 14'd0)
                                                         : (w_eff != '0);
    end
  end

  // next emitting segment
  always_comb begin
    found = 1'b0;
    s_sel = '0;
    sel_v = '0;
    any_e = 1'b0;
    rest  = 1'b0;
    e_pos = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (i == int'(seg_pos)) begin
        e_pos = (seg_v[i][1:0] == sts_pkg::SEG_GENERIC) ? (seg_v[i][15:2] != 14'd0)
                                                        : (CW'(pix_pos) < w_eff);
      end
    end
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (i < int'(n_eff) && !found &&
          ((i > int'(seg_pos) && e0[i]) || (i == int'(seg_pos) && e_pos))) begin
        found = 1'b1;
        s_sel = SW'(i);
        sel_v = seg_v[i];
      end
    end
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (i < int'(n_eff) && e0[i]) begin
        any_e = 1'b1;
        if (i > int'(s_sel)) rest = 1'b1;
      end
    end
    pix         = (s_sel == seg_pos) ? pix_pos : '0;
    pix_inc     = CW'(pix) + CW'(1);
    sel_generic = (sel_v[1:0] == sts_pkg::SEG_GENERIC);
    scan_end    = (pix_inc >= w_eff);
    line_last   = (sel_generic || scan_end) && !rest;
    gen_freq    = (sel_v[29:28] != 2'd0) ? 16'hFFFF : {sel_v[27:16], 4'd0};
    is_scottie  = (vis_code == sts_pkg::VIS_SCOTTIE_1) || (vis_code == sts_pkg::VIS_SCOTTIE_2)
               || (vis_code == sts_pkg::VIS_SCOTTIE_DX);
    do_sync     = (seg_pos == '0) && (pix_pos == '0) && first_line_pending && is_scottie;
    rd_addr     = pix;
  end

  assign out_free  = !tone_valid || !tone_stall;
  assign s1_done   = s1_valid && out_free &&
                     (s1_kind != K_HEADER || s1_count == sts_pkg::HDR_STOP);
  assign cmd_stall = s1_valid && !s1_done;
  assign accept    = cmd_valid && !cmd_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vis_code          <= sts_pkg::VIS_CODE_RST;
      line_width        <= sts_pkg::LINE_WIDTH_RST;
      pixel_duration_us <= sts_pkg::PIXEL_DUR_RST;
      segment_count     <= sts_pkg::SEG_COUNT_RST;
      for (int i = 0; i < 4; i++) segment_pair[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sts_pkg::CFG_VIS_CODE:   vis_code          <= cfg_data[6:0];
        sts_pkg::CFG_LINE_WIDTH: line_width        <= cfg_data[9:0];
        sts_pkg::CFG_PIXEL_DUR:  pixel_duration_us <= cfg_data[13:0];
        sts_pkg::CFG_SEG_COUNT:  segment_count     <= cfg_data[3:0];
        sts_pkg::CFG_PAIR_0:     segment_pair[0]   <= cfg_data;
        sts_pkg::CFG_PAIR_1:     segment_pair[1]   <= cfg_data;
        sts_pkg::CFG_PAIR_2:     segment_pair[2]   <= cfg_data;
        sts_pkg::CFG_PAIR_3:     segment_pair[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (accept && cmd.func == sts_pkg::FUNC_LOAD && 32'(cmd.pixel_index) < MAX_WIDTH) begin
      line_store[cmd.pixel_index[PW-1:0]] <= cmd.pixel_rgb;
    end
    if (accept) begin
      rd_data <= line_store[rd_addr];
    end
  end

  // line position and first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_pos            <= '0;
      pix_pos            <= '0;
      first_line_pending <= 1'b0;
      s1_valid           <= 1'b0;
      s1_count           <= '0;
    end else begin
      if (s1_valid && s1_kind == K_HEADER && out_free && s1_count != sts_pkg::HDR_STOP) begin
        s1_count <= s1_count + 4'd1;
      end
      if (s1_done && !accept) s1_valid <= 1'b0;
      if (accept) begin
        case (cmd.func)
          sts_pkg::FUNC_HEADER: begin
            first_line_pending <= 1'b1;
            seg_pos            <= '0;
            pix_pos            <= '0;
            s1_valid           <= 1'b1;
            s1_kind            <= K_HEADER;
            s1_count           <= sts_pkg::HDR_LEADER_A;
          end
          sts_pkg::FUNC_TICK: begin
            if (do_sync) begin
              first_line_pending <= 1'b0;
              s1_valid           <= 1'b1;
              s1_kind            <= K_DIRECT;
              s1_freq            <= sts_pkg::F_BREAK;
              s1_dur             <= sts_pkg::SYNC_US;
              s1_last            <= !any_e;
            end else if (!found) begin
              seg_pos  <= '0;
              pix_pos  <= '0;
              s1_valid <= 1'b0;
            end else begin
              s1_valid <= 1'b1;
              s1_last  <= line_last;
              s1_chan  <= sel_v[1:0];
              if (sel_generic) begin
                s1_kind <= K_DIRECT;
                s1_freq <= gen_freq;
                s1_dur  <= {5'd0, sel_v[15:2]};
              end else begin
                s1_kind <= K_PIXEL;
                s1_dur  <= {5'd0, pixel_duration_us};
              end
              if (line_last) begin
                seg_pos <= '0;
                pix_pos <= '0;
              end else if (sel_generic || scan_end) begin
                seg_pos <= s_sel + SW'(1);
                pix_pos <= '0;
              end else begin
                seg_pos <= s_sel;
                pix_pos <= pix_inc[PW-1:0];
              end
            end
          end
          default: s1_valid <= 1'b0;
        endcase
      end
    end
  end

  // result formation
  always_comb begin
    case (s1_chan)
      sts_pkg::SEG_RED:   colour = rd_data[23:16];
      sts_pkg::SEG_GREEN: colour = rd_data[15:8];
      default:            colour = rd_data[7:0];
    endcase
    parity    = ^vis_code;
    tone_next = '{tone_freq: s1_freq, tone_duration_us: s1_dur, last: s1_last};
    case (s1_kind)
      K_PIXEL: tone_next.tone_freq = sts_pkg::bright_freq(colour);
      K_HEADER: begin
        tone_next.last = 1'b0;
        case (s1_count) inside
          sts_pkg::HDR_LEADER_A, sts_pkg::HDR_LEADER_B: begin
            tone_next.tone_freq        = sts_pkg::F_LEADER;
            tone_next.tone_duration_us = sts_pkg::LEADER_US;
          end
          sts_pkg::HDR_BREAK: begin
            tone_next.tone_freq        = sts_pkg::F_BREAK;
            tone_next.tone_duration_us = sts_pkg::BREAK_US;
          end
          sts_pkg::HDR_START: begin
            tone_next.tone_freq        = sts_pkg::F_BREAK;
            tone_next.tone_duration_us = sts_pkg::BIT_US;
          end
          [sts_pkg::HDR_BIT_0:sts_pkg::HDR_BIT_6]: begin
            tone_next.tone_freq        = vis_code[3'(s1_count - sts_pkg::HDR_BIT_0)]
                                         ? sts_pkg::F_VIS1 : sts_pkg::F_VIS0;
            tone_next.tone_duration_us = sts_pkg::BIT_US;
          end
          sts_pkg::HDR_PARITY: begin
            tone_next.tone_freq        = parity ? sts_pkg::F_VIS1 : sts_pkg::F_VIS0;
            tone_next.tone_duration_us = sts_pkg::BIT_US;
          end
          sts_pkg::HDR_STOP: begin
            tone_next.tone_freq        = sts_pkg::F_BREAK;
            tone_next.tone_duration_us = sts_pkg::BIT_US;
            tone_next.last             = 1'b1;
          end
          default: begin
            tone_next.tone_freq        = sts_pkg::F_BREAK;
            tone_next.tone_duration_us = sts_pkg::BIT_US;
          end
        endcase
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_valid <= 1'b0;
    end else if (out_free) begin
      tone_valid <= s1_valid;
      if (s1_valid) tone <= tone_next;
    end
  end

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !cmd_stall)
    else $error("command stalled with empty first stage");

  a_header_count_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_kind == K_HEADER) |-> (s1_count <= sts_pkg::HDR_STOP))
    else $error("header tone count out of range");

  a_header_start: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.func == sts_pkg::FUNC_HEADER) |=>
      (s1_valid && s1_kind == K_HEADER && s1_count == sts_pkg::HDR_LEADER_A &&
       seg_pos == '0 && pix_pos == '0))
    else $error("header did not start at first tone");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tone sequencer. Sends pixel loads, header and
// line tick commands over the stall handshake. A predictor tracks the line
// store, the line position and the registers, and forms the expected tones
// for each accepted command. Every tone that leaves the block is compared
// field by field with the oldest expected tone. The run covers directed
// corner lines, random traffic under several idling mixes, and a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int STORE_DEPTH  = 640;
  localparam int SEG_SLOTS    = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 250;

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  sts_pkg::cmd_t  cmd;
  logic           tone_valid;
  logic           tone_stall = 1'b0;
  sts_pkg::tone_t tone;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [2:0]     cfg_index;
  logic [59:0]    cfg_data;

  // predictor state
  logic [23:0] pix_mem [STORE_DEPTH];
  bit          pix_loaded [STORE_DEPTH];
  logic [6:0]  vis_reg;
  logic [9:0]  width_reg;
  logic [13:0] pix_dur_reg;
  logic [3:0]  seg_cnt_reg;
  logic [59:0] pair_reg [4];
  int          seg_at;
  int          pix_at;
  bit          sync_armed;

  sts_pkg::tone_t tones_due [$];
  sts_pkg::tone_t tone_want;
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  logic [29:0] demo_seg [SEG_SLOTS];

  sstv_tone_sequencer_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .tone_valid (tone_valid),
    .tone_stall (tone_stall),
    .tone       (tone),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [29:0] seg_word(int s);
    logic [59:0] pair;
    pair = pair_reg[(s >> 1) & 3];
    return ((s & 1) != 0) ? pair[59:30] : pair[29:0];
  endfunction

  function automatic int active_segs();
    return (seg_cnt_reg > SEG_SLOTS) ? SEG_SLOTS : int'(seg_cnt_reg);
  endfunction

  function automatic int active_width();
    return (width_reg > STORE_DEPTH) ? STORE_DEPTH : int'(width_reg);
  endfunction

  function automatic bit seg_live(int s, int pix);
    logic [29:0] w;
    w = seg_word(s);
    if (w[1:0] == sts_pkg::SEG_GENERIC) return w[15:2] != 14'd0;
    return pix < active_width();
  endfunction

  function automatic int next_live(int s, int pix);
    int i;
    for (i = s; i < active_segs(); i++) begin
      if (seg_live(i, (i == s) ? pix : 0)) return i;
    end
    return active_segs();
  endfunction

  function automatic void push_tone(int f, int d, bit last);
    sts_pkg::tone_t t;
    t.tone_freq        = 16'(f);
    t.tone_duration_us = 19'(d);
    t.last             = last;
    tones_due.push_back(t);
  endfunction

  function automatic logic [29:0] seg(logic [1:0] kind, logic [13:0] dur, logic [13:0] hz);
    return {hz, dur, kind};
  endfunction

  function automatic logic [29:0] rand_seg();
    logic [29:0] w;
    w = 30'($urandom);
    if ($urandom_range(3) == 0) w[15:2] = '0;
    return w;
  endfunction

  function automatic sts_pkg::cmd_t mk_cmd(logic [1:0] f, logic [9:0] idx, logic [23:0] rgb);
    sts_pkg::cmd_t c;
    c.func        = f;
    c.pixel_index = idx;
    c.pixel_rgb   = rgb;
    return c;
  endfunction

  // expected tones of one accepted word
  function automatic void track_cmd(sts_pkg::cmd_t c);
    int n, s, pix, ns, np, f, d, ones, b;
    logic [29:0] w;
    logic [23:0] px;
    logic [7:0]  shade;
    case (c.func)
      sts_pkg::FUNC_LOAD: begin
        if (c.pixel_index < STORE_DEPTH) begin
          pix_mem[c.pixel_index]    = c.pixel_rgb;
          pix_loaded[c.pixel_index] = 1'b1;
        end
      end
      sts_pkg::FUNC_HEADER: begin
        sync_armed = 1'b1;
        seg_at = 0;
        pix_at = 0;
        push_tone(sts_pkg::F_LEADER, sts_pkg::LEADER_US, 1'b0);
        push_tone(sts_pkg::F_BREAK, sts_pkg::BREAK_US, 1'b0);
        push_tone(sts_pkg::F_LEADER, sts_pkg::LEADER_US, 1'b0);
        push_tone(sts_pkg::F_BREAK, sts_pkg::BIT_US, 1'b0);
        ones = 0;
        for (b = 0; b < 7; b++) begin
          if (vis_reg[b]) ones++;
          push_tone(vis_reg[b] ? sts_pkg::F_VIS1 : sts_pkg::F_VIS0, sts_pkg::BIT_US, 1'b0);
        end
        push_tone(((ones % 2) != 0) ? sts_pkg::F_VIS1 : sts_pkg::F_VIS0,
                  sts_pkg::BIT_US, 1'b0);
        push_tone(sts_pkg::F_BREAK, sts_pkg::BIT_US, 1'b1);
      end
      sts_pkg::FUNC_TICK: begin
        n = active_segs();
        if (seg_at == 0 && pix_at == 0 && sync_armed &&
            (vis_reg == sts_pkg::VIS_SCOTTIE_1 || vis_reg == sts_pkg::VIS_SCOTTIE_2 ||
             vis_reg == sts_pkg::VIS_SCOTTIE_DX)) begin
          sync_armed = 1'b0;
          push_tone(sts_pkg::F_BREAK, sts_pkg::SYNC_US, next_live(0, 0) >= n);
        end else begin
          s = next_live(seg_at, pix_at);
          if (s >= n) begin
            seg_at = 0;
            pix_at = 0;
          end else begin
            pix = (s == seg_at) ? pix_at : 0;
            w = seg_word(s);
            if (w[1:0] == sts_pkg::SEG_GENERIC) begin
              f = w[29:16] * 16;
              if (f > 65535) f = 65535;
              d = w[15:2];
              ns = s + 1;
              np = 0;
            end else begin
              px = pix_mem[pix];
              shade = (w[1:0] == sts_pkg::SEG_RED) ? px[23:16] :
                      (w[1:0] == sts_pkg::SEG_GREEN) ? px[15:8] : px[7:0];
              f = sts_pkg::F_BRIGHT_MIN + (shade * 12800 + 127) / 255;
              d = pix_dur_reg;
              if (pix + 1 >= active_width()) begin
                ns = s + 1;
                np = 0;
              end else begin
                ns = s;
                np = pix + 1;
              end
            end
            if (next_live(ns, np) >= n) begin
              seg_at = 0;
              pix_at = 0;
              push_tone(f, d, 1'b1);
            end else begin
              seg_at = ns;
              pix_at = np;
              push_tone(f, d, 1'b0);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_cmd(sts_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    track_cmd(c);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (tones_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [59:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sts_pkg::CFG_VIS_CODE:   vis_reg = val[6:0];
      sts_pkg::CFG_LINE_WIDTH: width_reg = val[9:0];
      sts_pkg::CFG_PIXEL_DUR:  pix_dur_reg = val[13:0];
      sts_pkg::CFG_SEG_COUNT:  seg_cnt_reg = val[3:0];
      sts_pkg::CFG_PAIR_0:     pair_reg[0] = val;
      sts_pkg::CFG_PAIR_1:     pair_reg[1] = val;
      sts_pkg::CFG_PAIR_2:     pair_reg[2] = val;
      sts_pkg::CFG_PAIR_3:     pair_reg[3] = val;
      default: begin
      end
    endcase
  endtask

  task automatic load_setup(logic [6:0] vis, logic [9:0] width, logic [13:0] dur,
                            logic [3:0] count, logic [59:0] p0, logic [59:0] p1,
                            logic [59:0] p2, logic [59:0] p3);
    settle();
    write_reg(sts_pkg::CFG_VIS_CODE, 60'(vis));
    write_reg(sts_pkg::CFG_LINE_WIDTH, 60'(width));
    write_reg(sts_pkg::CFG_PIXEL_DUR, 60'(dur));
    write_reg(sts_pkg::CFG_SEG_COUNT, 60'(count));
    write_reg(sts_pkg::CFG_PAIR_0, p0);
    write_reg(sts_pkg::CFG_PAIR_1, p1);
    write_reg(sts_pkg::CFG_PAIR_2, p2);
    write_reg(sts_pkg::CFG_PAIR_3, p3);
    cfg_valid <= 1'b0;
  endtask

  // every entry a line can reach holds a loaded pixel
  task automatic fill_store(int reach);
    int i;
    for (i = 0; i < active_width() && i < reach; i++) begin
      if (!pix_loaded[i]) send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'(i), 24'($urandom)));
    end
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_cmd(mk_cmd(sts_pkg::FUNC_TICK, '0, '0));
  endtask

  task automatic test_reset_state();
    send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'd1023, 24'hFFFFFF));
    send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'd640, 24'h123456));
    send_cmd(mk_cmd(FUNC_NONE, 10'h3FF, 24'hFFFFFF));
    send_ticks(3);
  endtask

  task automatic test_line_segments();
    demo_seg[0] = seg(sts_pkg::SEG_GENERIC, 14'd4862, 14'd1200);
    demo_seg[1] = seg(sts_pkg::SEG_GREEN, 14'd0, 14'd0);
    demo_seg[2] = seg(sts_pkg::SEG_GENERIC, 14'd572, 14'd1500);
    demo_seg[3] = seg(sts_pkg::SEG_BLUE, 14'd3, 14'd7);
    demo_seg[4] = seg(sts_pkg::SEG_GENERIC, 14'd0, 14'd1200);
    demo_seg[5] = seg(sts_pkg::SEG_RED, 14'h3FFF, 14'h3FFF);
    demo_seg[6] = seg(sts_pkg::SEG_GENERIC, 14'h3FFF, 14'h3FFF);
    demo_seg[7] = seg(sts_pkg::SEG_GENERIC, 14'd1, 14'd0);
    load_setup(7'h7F, 10'd3, 14'h3FFF, 4'd8,
               {demo_seg[1], demo_seg[0]}, {demo_seg[3], demo_seg[2]},
               {demo_seg[5], demo_seg[4]}, {demo_seg[7], demo_seg[6]});
    send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'd0, 24'h000000));
    send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'd1, 24'hFFFFFF));
    send_cmd(mk_cmd(sts_pkg::FUNC_LOAD, 10'd2, 24'h808080));
    fill_store(STORE_DEPTH);
    send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_ticks(14);
    send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_ticks(2);
  endtask

  task automatic test_edge_config();
    load_setup(sts_pkg::VIS_SCOTTIE_DX, 10'd0, 14'd0, 4'd15,
               {demo_seg[1], demo_seg[0]}, {demo_seg[3], demo_seg[2]},
               {demo_seg[5], demo_seg[4]}, {demo_seg[7], demo_seg[6]});
    send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_ticks(6);
    load_setup(7'd0, 10'd1, 14'd1, 4'd0, '1, '1, '1, '1);
    fill_store(STORE_DEPTH);
    send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_ticks(2);
  endtask

  task automatic test_random_traffic(int sidle, int rstall, int count, bit wide);
    logic [6:0] vis;
    logic [9:0] width;
    logic [3:0] segs;
    int r;
    sts_pkg::cmd_t c;
    case ($urandom_range(3))
      0: vis = sts_pkg::VIS_SCOTTIE_1;
      1: vis = sts_pkg::VIS_SCOTTIE_2;
      2: vis = sts_pkg::VIS_SCOTTIE_DX;
      default: vis = 7'($urandom);
    endcase
    if (wide) width = 10'($urandom_range(640, 1023));
    else if ($urandom_range(9) == 0) width = 10'd0;
    else width = 10'($urandom_range(1, 6));
    if ($urandom_range(4) == 0) segs = 4'($urandom);
    else segs = 4'($urandom_range(2, 8));
    load_setup(vis, width, 14'($urandom), segs,
               {rand_seg(), rand_seg()}, {rand_seg(), rand_seg()},
               {rand_seg(), rand_seg()}, {rand_seg(), rand_seg()});
    // a line advances one pixel per tick at most
    fill_store(pix_at + count + 1);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    repeat (count) begin
      r = $urandom_range(99);
      c.pixel_index = 10'($urandom);
      c.pixel_rgb   = 24'($urandom);
      if (r < 6) c.func = sts_pkg::FUNC_HEADER;
      else if (r < 26) c.func = sts_pkg::FUNC_LOAD;
      else if (r < 29) c.func = FUNC_NONE;
      else c.func = sts_pkg::FUNC_TICK;
      send_cmd(c);
    end
  endtask

  task automatic test_backpressure();
    load_setup(sts_pkg::VIS_SCOTTIE_2, 10'd4, 14'd100, 4'd8,
               {demo_seg[1], demo_seg[0]}, {demo_seg[3], demo_seg[2]},
               {demo_seg[5], demo_seg[4]}, {demo_seg[7], demo_seg[6]});
    fill_store(STORE_DEPTH);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    repeat (2) send_cmd(mk_cmd(sts_pkg::FUNC_HEADER, '0, '0));
    send_ticks(30);
  endtask

  // receiver side: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      tone_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      tone_stall <= 1'b1;
    end else begin
      tone_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && tone_valid && !tone_stall) begin
      if (tones_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected tone word: freq %0d dur %0d last %0d",
                   tone.tone_freq, tone.tone_duration_us, tone.last);
      end else begin
        tone_want = tones_due.pop_front();
        if (tone.tone_freq !== tone_want.tone_freq ||
            tone.tone_duration_us !== tone_want.tone_duration_us ||
            tone.last !== tone_want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tone mismatch: freq %0d/%0d dur %0d/%0d last %0d/%0d (exp/act)",
                     tone_want.tone_freq, tone.tone_freq,
                     tone_want.tone_duration_us, tone.tone_duration_us,
                     tone_want.last, tone.last);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** sstv_tone_sequencer_unit: FAILED **");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    vis_reg     = sts_pkg::VIS_CODE_RST;
    width_reg   = sts_pkg::LINE_WIDTH_RST;
    pix_dur_reg = sts_pkg::PIXEL_DUR_RST;
    seg_cnt_reg = sts_pkg::SEG_COUNT_RST;
    foreach (pair_reg[i]) pair_reg[i] = '0;
    foreach (pix_loaded[i]) pix_loaded[i] = 1'b0;
    seg_at     = 0;
    pix_at     = 0;
    sync_armed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_line_segments();
    test_edge_config();
    test_random_traffic(0, 0, 70, 1'b0);
    test_random_traffic(65, 0, 70, 1'b1);
    test_random_traffic(0, 65, 70, 1'b0);
    test_random_traffic(17, 17, 70, 1'b0);
    test_backpressure();
    settle();

    if (mismatches == 0 && tones_due.size() == 0) begin
      $display("** sstv_tone_sequencer_unit: PASSED **");
    end else begin
      $display("** sstv_tone_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sts_pkg.sv
rtl/sstv_tone_sequencer_unit.sv
test/testbench.sv
